// ===== rtl/agi_pkg.sv =====
package agi_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int SHIFT_W     = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [SHIFT_W-1:0]     shift_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_VAL_OUT
    } agi_state_t;

endpackage

// ===== rtl/agi_gcd_unit.sv =====
module agi_gcd_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  agi_pkg::value_t op_a,
    input  agi_pkg::value_t op_b,
    output logic            done,
    output agi_pkg::value_t result
);
    import agi_pkg::*;

    value_t a_reg, a_next;
    value_t b_reg, b_next;
    shift_t k_reg, k_next;
    logic   run_reg, run_next;

    logic [VALUE_WIDTH:0] diff;
    logic                 zero;

    assign diff   = {1'b0, a_reg} - {1'b0, b_reg};
    assign zero   = (a_reg == '0) || (b_reg == '0);
    assign done   = run_reg && zero;
    // one operand is zero here, so the OR is the other one
    assign result = (a_reg | b_reg) << k_reg;

    // binary gcd, one step a cycle
    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        k_next   = k_reg;
        run_next = run_reg;
        if (start)
        begin
            a_next   = op_a;
            b_next   = op_b;
            k_next   = '0;
            run_next = 1'b1;
        end
        else if (run_reg && !zero)
        begin
            if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + shift_t'(1);
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (!diff[VALUE_WIDTH])
            begin
                a_next = diff[VALUE_WIDTH-1:0];
            end
            else
            begin
                b_next = b_reg - a_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
    end

endmodule

// ===== rtl/adjacent_gcd_inserter_top.sv =====
// channel | signals                    | payload
// --------+----------------------------+---------------------------------------------
// in      | in_valid / in_ready        | value, end_of_list
// out     | out_valid / out_ready      | result_value, is_divisor, last_of_run, list_done
//
// First item of a list: accept, then emit. Later items: accept, then the shared
// binary gcd unit takes one step a cycle, then the gcd and then the element are
// emitted through the output register. Each subtract step that leaves no zero is
// followed by a halving step, which bounds the step count S below 4*VALUE_WIDTH;
// 0xFFFFFFFF with 0x7FFFFFFF takes 93 steps.
// Reset clears the previous-element flag and all handshake state.
// in_ready is high only in idle; a result waiting at the output does not block
// the next accept, and a stalled output holds the finished gcd or the element.
module adjacent_gcd_inserter_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  agi_pkg::value_t value,
    input  logic            end_of_list,
    output logic            out_valid,
    input  logic            out_ready,
    output agi_pkg::value_t result_value,
    output logic            is_divisor,
    output logic            last_of_run,
    output logic            list_done
);
    import agi_pkg::*;

    agi_state_t state_reg, state_next;
    value_t     prev_reg, prev_next;
    logic       have_prev_reg, have_prev_next;
    value_t     cur_reg, cur_next;
    logic       eol_reg, eol_next;

    logic       out_valid_reg, out_valid_next;
    value_t     out_value_reg, out_value_next;
    logic       out_div_reg, out_div_next;
    logic       out_last_reg, out_last_next;
    logic       out_done_reg, out_done_next;

    logic       gcd_start;
    logic       gcd_done;
    value_t     gcd_result;
    logic       out_free;

    agi_gcd_unit u_gcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (gcd_start),
        .op_a   (prev_reg),
        .op_b   (value),
        .done   (gcd_done),
        .result (gcd_result)
    );

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        cur_next       = cur_reg;
        eol_next       = eol_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_div_next   = out_div_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        in_ready       = 1'b0;
        gcd_start      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cur_next       = value;
                    eol_next       = end_of_list;
                    prev_next      = end_of_list ? '0 : value;
                    have_prev_next = !end_of_list;
                    if (have_prev_reg)
                    begin
                        gcd_start  = 1'b1;
                        state_next = ST_CALC;
                    end
                    else
                    begin
                        state_next = ST_VAL_OUT;
                    end
                end
            end
            ST_CALC:
            begin
                if (gcd_done && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = gcd_result;
                    out_div_next   = 1'b1;
                    out_last_next  = 1'b0;
                    out_done_next  = 1'b0;
                    state_next     = ST_VAL_OUT;
                end
            end
            ST_VAL_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = cur_reg;
                    out_div_next   = 1'b0;
                    out_last_next  = 1'b1;
                    out_done_next  = eol_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            have_prev_reg <= have_prev_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        eol_reg       <= eol_next;
        out_value_reg <= out_value_next;
        out_div_reg   <= out_div_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign is_divisor   = out_div_reg;
    assign last_of_run  = out_last_reg;
    assign list_done    = out_done_reg;

endmodule

// ===== rtl/agi_checker.sv =====
module agi_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input agi_pkg::value_t value,
    input logic            end_of_list,
    input logic            out_valid,
    input logic            out_ready,
    input agi_pkg::value_t result_value,
    input logic            is_divisor,
    input logic            last_of_run,
    input logic            list_done
);
    import agi_pkg::*;

    // one item in flight: ready drops right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after accept");

    a_div_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_divisor |-> !last_of_run && !list_done)
        else $error("divisor item carries end flags");

    a_elem_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_divisor |-> last_of_run)
        else $error("element item without last_of_run");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value)
            && $stable(is_divisor) && $stable(list_done))
        else $error("stalled output item changed");

endmodule

bind adjacent_gcd_inserter_top agi_checker u_agi_checker (.*);
